// ===== sv/xab_pkg.sv =====
// Shared types, codes and constants of the XOR accelerator register block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package xab_pkg;

   // Payload widths.
   localparam int unsigned CMD_W    = 3;
   localparam int unsigned OFFS_W   = 12;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned NOISE_W  = 5;
   localparam int unsigned ROLL_W   = 7;
   localparam int unsigned INDEX_W  = 16;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned TEMP_W   = 7;
   localparam int unsigned STATUS_W = 4;
   localparam int unsigned FLAGS_W  = 4;
   localparam int unsigned IRQ_W    = 3;

   // Item commands.
   typedef enum logic [CMD_W-1:0] {
      CMD_READ     = 3'd0,
      CMD_WRITE    = 3'd1,
      CMD_COMPLETE = 3'd2,
      CMD_TICK     = 3'd3,
      CMD_FAULT    = 3'd4,
      CMD_BYTE     = 3'd5
   } cmd_type;

   // Register offsets in the 4 KiB window.
   localparam logic [OFFS_W-1:0] OFS_ID       = 12'h000;
   localparam logic [OFFS_W-1:0] OFS_STATUS   = 12'h004;
   localparam logic [OFFS_W-1:0] OFS_CONTROL  = 12'h008;
   localparam logic [OFFS_W-1:0] OFS_KEY      = 12'h00C;
   localparam logic [OFFS_W-1:0] OFS_SRC_LO   = 12'h010;
   localparam logic [OFFS_W-1:0] OFS_SRC_HI   = 12'h014;
   localparam logic [OFFS_W-1:0] OFS_DST_LO   = 12'h018;
   localparam logic [OFFS_W-1:0] OFS_DST_HI   = 12'h01C;
   localparam logic [OFFS_W-1:0] OFS_LENGTH   = 12'h020;
   localparam logic [OFFS_W-1:0] OFS_IRQ_STAT = 12'h024;
   localparam logic [OFFS_W-1:0] OFS_IRQ_MASK = 12'h028;
   localparam logic [OFFS_W-1:0] OFS_DONE_CNT = 12'h02C;
   localparam logic [OFFS_W-1:0] OFS_RESET    = 12'h030;
   localparam logic [OFFS_W-1:0] OFS_ERR_CNT  = 12'h034;
   localparam logic [OFFS_W-1:0] OFS_TEMP     = 12'h038;

   // Configuration port register index.
   localparam logic [1:0] CSR_MSI_MODE = 2'd0;

   // Fixed values.
   localparam logic [DATA_W-1:0] ID_VALUE      = 32'hC0DEC4FE;
   localparam logic [DATA_W-1:0] RESET_MAGIC   = 32'hDEADBEEF;
   localparam logic [DATA_W-1:0] BUFFER_BYTES  = 32'd65536;
   localparam logic [TEMP_W-1:0] TEMP_MEAN     = 7'd72;
   localparam logic [TEMP_W-1:0] TEMP_LIMIT    = 7'd100;
   localparam logic [TEMP_W-1:0] TEMP_LOW      = 7'd45;
   localparam logic [TEMP_W-1:0] TEMP_HIGH     = 7'd115;
   localparam logic [ROLL_W-1:0] FAULT_PERCENT = 7'd15;

   // Status bits.
   localparam logic [STATUS_W-1:0] ST_IDLE  = 4'b0001;
   localparam logic [STATUS_W-1:0] ST_BUSY  = 4'b0010;
   localparam logic [STATUS_W-1:0] ST_DONE  = 4'b0100;
   localparam logic [STATUS_W-1:0] ST_ERROR = 4'b1000;

   // Pending interrupt bits.
   localparam logic [IRQ_W-1:0] IRQ_DONE = 3'b001;
   localparam logic [IRQ_W-1:0] IRQ_ERR  = 3'b010;
   localparam logic [IRQ_W-1:0] IRQ_TEMP = 3'b100;

   // Job flag bits.
   localparam int unsigned FLAG_IRQ_EN  = 0;
   localparam int unsigned FLAG_ENCRYPT = 3;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic [OFFS_W-1:0]         reg_offset;
      logic [DATA_W-1:0]         write_data;
      logic signed [NOISE_W-1:0] temp_noise;
      logic [ROLL_W-1:0]         fault_roll;
      logic [INDEX_W-1:0]        byte_index;
      logic [BYTE_W-1:0]         byte_value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_level;
      logic              msi_pulse;
      logic [BYTE_W-1:0] xored_byte;
      logic              job_started;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/xab_req_if.sv =====
// Request channel interface: valid/ready handshake plus the item fields.
// Depends on xab_pkg for the field widths.
`default_nettype none

interface xab_req_if;
   import xab_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic [OFFS_W-1:0]         reg_offset;
   logic [DATA_W-1:0]         write_data;
   logic signed [NOISE_W-1:0] temp_noise;
   logic [ROLL_W-1:0]         fault_roll;
   logic [INDEX_W-1:0]        byte_index;
   logic [BYTE_W-1:0]         byte_value;

   modport source (
      output valid, cmd, reg_offset, write_data, temp_noise, fault_roll,
             byte_index, byte_value,
      input  ready
   );

   modport sink (
      input  valid, cmd, reg_offset, write_data, temp_noise, fault_roll,
             byte_index, byte_value,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/xab_rsp_if.sv =====
// Response channel interface: valid/ready handshake plus the result fields.
// Depends on xab_pkg for the field widths.
`default_nettype none

interface xab_rsp_if;
   import xab_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              irq_level;
   logic              msi_pulse;
   logic [BYTE_W-1:0] xored_byte;
   logic              job_started;

   modport source (
      output valid, read_data, irq_level, msi_pulse, xored_byte, job_started,
      input  ready
   );

   modport sink (
      input  valid, read_data, irq_level, msi_pulse, xored_byte, job_started,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/xab_temp.sv =====
// Temperature step: mean-reverting pull, noise, clamp and high-crossing detect.
// Depends on xab_pkg.
`default_nettype none

module xab_temp (
   input  wire logic [xab_pkg::TEMP_W-1:0]         temp_cur,
   input  wire logic signed [xab_pkg::NOISE_W-1:0] noise,
   output logic [xab_pkg::TEMP_W-1:0]              temp_next,
   output logic                                    crossed
);
   import xab_pkg::*;

   logic signed [8:0]  diff;
   logic [6:0]         mag;
   logic [14:0]        prod;
   logic [4:0]         quot;
   logic signed [8:0]  pull;
   logic signed [9:0]  sum;

   // Division by five as a multiply by 205/1024; exact for magnitudes below 128.
   always_comb begin
      diff = $signed({2'b00, TEMP_MEAN}) - $signed({2'b00, temp_cur});
      mag  = diff[8] ? 7'(-diff) : diff[6:0];
      prod = 15'(mag) * 15'd205;
      quot = prod[14:10];
      pull = diff[8] ? -$signed({4'b0000, quot}) : $signed({4'b0000, quot});
      sum  = $signed({3'b000, temp_cur}) + 10'(noise) + 10'(pull);
      if (sum < $signed({3'b000, TEMP_LOW})) begin
         temp_next = TEMP_LOW;
      end else if (sum > $signed({3'b000, TEMP_HIGH})) begin
         temp_next = TEMP_HIGH;
      end else begin
         temp_next = sum[TEMP_W-1:0];
      end
      crossed = (temp_next > TEMP_LIMIT) && (temp_cur <= TEMP_LIMIT);
   end

endmodule

`default_nettype wire

// ===== sv/xab_core.sv =====
// Register file and per-item update logic of the XOR accelerator block.
// Depends on xab_pkg and instantiates xab_temp.
`default_nettype none

module xab_core #(
   parameter logic [xab_pkg::DATA_W-1:0] BUFFER_BYTES = xab_pkg::BUFFER_BYTES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic             msi_mode,
   input  wire xab_pkg::req_type item,
   output xab_pkg::rsp_type      result
);
   import xab_pkg::*;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [FLAGS_W-1:0]  flags_ff, flags_in;
   logic [DATA_W-1:0]   key_ff, key_in;
   logic [63:0]         src_ff, src_in;
   logic [63:0]         dst_ff, dst_in;
   logic [DATA_W-1:0]   len_ff, len_in;
   logic [IRQ_W-1:0]    pend_ff, pend_in;
   logic [DATA_W-1:0]   mask_ff, mask_in;
   logic [DATA_W-1:0]   done_cnt_ff, done_cnt_in;
   logic [DATA_W-1:0]   err_cnt_ff, err_cnt_in;
   logic [TEMP_W-1:0]   temp_ff, temp_in;
   logic                line_ff, line_in;

   logic [TEMP_W-1:0]   temp_step;
   logic                temp_crossed;
   logic [IRQ_W-1:0]    raise;
   logic                len_over;
   logic [BYTE_W-1:0]   key_byte;

   xab_temp u_temp (
      .temp_cur  (temp_ff),
      .noise     (item.temp_noise),
      .temp_next (temp_step),
      .crossed   (temp_crossed)
   );

   assign len_over = len_ff > BUFFER_BYTES;

   always_comb begin
      case (item.byte_index[1:0])
         2'd0:    key_byte = key_ff[7:0];
         2'd1:    key_byte = key_ff[15:8];
         2'd2:    key_byte = key_ff[23:16];
         default: key_byte = key_ff[31:24];
      endcase
   end

   always_comb begin
      status_in   = status_ff;
      flags_in    = flags_ff;
      key_in      = key_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      len_in      = len_ff;
      pend_in     = pend_ff;
      mask_in     = mask_ff;
      done_cnt_in = done_cnt_ff;
      err_cnt_in  = err_cnt_ff;
      temp_in     = temp_ff;
      line_in     = line_ff;
      raise       = '0;
      result      = '0;

      case (cmd_type'(item.cmd))
         CMD_READ: begin
            case (item.reg_offset)
               OFS_ID:       result.read_data = ID_VALUE;
               OFS_STATUS:   result.read_data = DATA_W'(status_ff);
               OFS_KEY:      result.read_data = key_ff;
               OFS_SRC_LO:   result.read_data = src_ff[31:0];
               OFS_SRC_HI:   result.read_data = src_ff[63:32];
               OFS_DST_LO:   result.read_data = dst_ff[31:0];
               OFS_DST_HI:   result.read_data = dst_ff[63:32];
               OFS_LENGTH:   result.read_data = len_ff;
               OFS_IRQ_STAT: result.read_data = DATA_W'(pend_ff);
               OFS_IRQ_MASK: result.read_data = mask_ff;
               OFS_DONE_CNT: result.read_data = done_cnt_ff;
               OFS_ERR_CNT:  result.read_data = err_cnt_ff;
               OFS_TEMP:     result.read_data = DATA_W'(temp_ff);
               default:      result.read_data = '0;
            endcase
         end
         CMD_WRITE: begin
            case (item.reg_offset)
               OFS_CONTROL: begin
                  if (item.write_data[0] && (status_ff & ST_BUSY) == '0) begin
                     if (len_over) begin
                        status_in  = ST_IDLE | ST_ERROR;
                        err_cnt_in = err_cnt_ff + 1'b1;
                        if (item.write_data[1]) begin
                           raise = IRQ_ERR;
                        end
                     end else begin
                        flags_in           = item.write_data[4:1];
                        status_in          = ST_BUSY;
                        result.job_started = 1'b1;
                     end
                  end
               end
               OFS_KEY:    key_in = item.write_data;
               OFS_SRC_LO: src_in = {src_ff[63:32], item.write_data};
               OFS_SRC_HI: src_in = {item.write_data, src_ff[31:0]};
               OFS_DST_LO: dst_in = {dst_ff[63:32], item.write_data};
               OFS_DST_HI: dst_in = {item.write_data, dst_ff[31:0]};
               OFS_LENGTH: len_in = item.write_data;
               OFS_IRQ_STAT: begin
                  pend_in = pend_ff & ~item.write_data[IRQ_W-1:0];
                  if (!msi_mode) begin
                     line_in = |(pend_in & mask_ff[IRQ_W-1:0]);
                  end
               end
               OFS_IRQ_MASK: begin
                  mask_in = item.write_data;
                  if (!msi_mode) begin
                     line_in = |(pend_ff & item.write_data[IRQ_W-1:0]);
                  end
               end
               OFS_RESET: begin
                  // Soft reset leaves the die temperature alone.
                  if (item.write_data == RESET_MAGIC) begin
                     status_in   = ST_IDLE;
                     flags_in    = '0;
                     key_in      = '0;
                     src_in      = '0;
                     dst_in      = '0;
                     len_in      = '0;
                     pend_in     = '0;
                     mask_in     = '0;
                     done_cnt_in = '0;
                     err_cnt_in  = '0;
                     if (!msi_mode) begin
                        line_in = 1'b0;
                     end
                  end
               end
               default: ;
            endcase
         end
         CMD_COMPLETE: begin
            if ((status_ff & ST_BUSY) != '0) begin
               if (len_over) begin
                  status_in  = ST_IDLE | ST_ERROR;
                  err_cnt_in = err_cnt_ff + 1'b1;
                  if (flags_ff[FLAG_IRQ_EN]) begin
                     raise = IRQ_ERR;
                  end
               end else begin
                  status_in   = ST_IDLE | ST_DONE;
                  done_cnt_in = done_cnt_ff + 1'b1;
                  if (flags_ff[FLAG_IRQ_EN]) begin
                     raise = IRQ_DONE;
                  end
               end
            end
         end
         CMD_TICK: begin
            temp_in = temp_step;
            if (temp_crossed) begin
               raise = IRQ_TEMP;
            end
         end
         CMD_FAULT: begin
            if ((status_ff & ST_IDLE) != '0 && item.fault_roll < FAULT_PERCENT) begin
               status_in  = ST_IDLE | ST_ERROR;
               err_cnt_in = err_cnt_ff + 1'b1;
               raise      = IRQ_ERR;
            end
         end
         CMD_BYTE: begin
            result.xored_byte = flags_ff[FLAG_ENCRYPT] ? (item.byte_value ^ key_byte)
                                                       : item.byte_value;
         end
         default: ;
      endcase

      // A raised interrupt is always latched; it pulses or drives the line by mode.
      if (raise != '0) begin
         pend_in = pend_in | raise;
         if (msi_mode) begin
            result.msi_pulse = 1'b1;
         end else begin
            line_in = 1'b1;
         end
      end
      result.irq_level = line_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff   <= ST_IDLE;
         flags_ff    <= '0;
         key_ff      <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
         len_ff      <= '0;
         pend_ff     <= '0;
         mask_ff     <= '0;
         done_cnt_ff <= '0;
         err_cnt_ff  <= '0;
         temp_ff     <= TEMP_MEAN;
         line_ff     <= 1'b0;
      end else if (fire) begin
         status_ff   <= status_in;
         flags_ff    <= flags_in;
         key_ff      <= key_in;
         src_ff      <= src_in;
         dst_ff      <= dst_in;
         len_ff      <= len_in;
         pend_ff     <= pend_in;
         mask_ff     <= mask_in;
         done_cnt_ff <= done_cnt_in;
         err_cnt_ff  <= err_cnt_in;
         temp_ff     <= temp_in;
         line_ff     <= line_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_xor_busy: assert property (@(posedge clock) disable iff (reset)
      ((status_ff & ST_IDLE) != '0) != ((status_ff & ST_BUSY) != '0))
      else $error("status is neither cleanly idle nor busy");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      temp_ff >= TEMP_LOW && temp_ff <= TEMP_HIGH)
      else $error("die temperature left its clamp range");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(done_cnt_ff) && $stable(err_cnt_ff) && $stable(status_ff))
      else $error("state changed without an item");

   a_pulse_only_msi: assert property (@(posedge clock) disable iff (reset)
      fire && !msi_mode |-> !result.msi_pulse)
      else $error("message pulse in level mode");
`endif

endmodule

`default_nettype wire

// ===== sv/xor_accelerator_register_block_top.sv =====
// Top level of the XOR accelerator register block: input register, result
// register, configuration port. Depends on xab_pkg, xab_req_if, xab_rsp_if, xab_core.
//
//   Channel   Direction  Handshake               Word
//   req_bus   in         valid/ready             one register access or event
//   rsp_bus   out        valid/ready             one result per request word
//   csr (APB) in         psel/penable, pready=1  msi_mode at byte address 0
//
// A request word is taken into the input register; whenever the result register is free
// or being emptied, the core updates its registers and loads the result register, so
// the block sustains one word per clock while rsp_bus does not stall.
// The rate is set by the single register update per word in xab_core.
// Reset is synchronous and active high; it clears all control state, the
// registers to their reset values, and the die temperature to 72 F.
// A stalled result holds in the result register while the input register still
// takes a new word; only when both are full does req_bus.ready drop.
`default_nettype none

module xor_accelerator_register_block_top #(
   parameter logic [xab_pkg::DATA_W-1:0] BUFFER_BYTES = xab_pkg::BUFFER_BYTES
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   xab_req_if.sink                          req_bus,
   xab_rsp_if.source                        rsp_bus,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [1:0]                  paddr,
   input  wire logic [xab_pkg::DATA_W-1:0]  pwdata,
   output logic [xab_pkg::DATA_W-1:0]       prdata,
   output logic                             pready
);
   import xab_pkg::*;

   // Input register stage.
   req_type in_ff;
   logic    in_valid_ff;

   // Result register stage.
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   rsp_type core_rsp;

   logic    msi_mode_ff;
   logic    advance;
   logic    take;
   logic    csr_write;

   // The core processes the held word whenever the result register is free
   // or being emptied in this same cycle.
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign take    = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   // Payload register carries no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         in_ff.cmd        <= req_bus.cmd;
         in_ff.reg_offset <= req_bus.reg_offset;
         in_ff.write_data <= req_bus.write_data;
         in_ff.temp_noise <= req_bus.temp_noise;
         in_ff.fault_roll <= req_bus.fault_roll;
         in_ff.byte_index <= req_bus.byte_index;
         in_ff.byte_value <= req_bus.byte_value;
      end
   end

   xab_core #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .msi_mode (msi_mode_ff),
      .item     (in_ff),
      .result   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.read_data   = rsp_ff.read_data;
   assign rsp_bus.irq_level   = rsp_ff.irq_level;
   assign rsp_bus.msi_pulse   = rsp_ff.msi_pulse;
   assign rsp_bus.xored_byte  = rsp_ff.xored_byte;
   assign rsp_bus.job_started = rsp_ff.job_started;

   // Configuration port: a single mode bit, always ready.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == CSR_MSI_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         msi_mode_ff <= 1'b0;
      end else if (csr_write) begin
         msi_mode_ff <= pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == CSR_MSI_MODE) begin
         prdata = DATA_W'(msi_mode_ff);
      end
   end

`ifndef SYNTHESIS
   a_advance_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed word did not reach the result register");

   a_held_word_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("waiting request word was lost or changed");

   a_stalled_rsp_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff)
      else $error("stalled result was dropped");

   a_start_no_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.job_started && rsp_ff.msi_pulse))
      else $error("job start reported together with an interrupt pulse");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the XOR accelerator register block: directed and random words on the request
// channel, every result checked against an in-bench model of the register file.
// Depends on xab_pkg, xab_req_if, xab_rsp_if and xor_accelerator_register_block_top.
`timescale 1ns / 100ps

module tb;
   import xab_pkg::*;

   // Cycles with no handshake on any port before the run is declared hung.
   localparam int HANG_LIMIT = 4000;
   // Divisor of the pull of the die temperature toward its mean.
   localparam int TEMP_PULL_DIV = 5;
   // Command codes the block leaves unused; they must still produce a result.
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset;

   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [1:0]        paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   xab_req_if req_bus ();
   xab_rsp_if rsp_bus ();

   xor_accelerator_register_block_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #4 clock = ~clock;

   // Idling odds, in percent, for the sender and for the receiver.
   int send_idle_pct = 0;
   int stall_pct = 0;
   int words_sent = 0;
   int failures = 0;

   // Results the accelerator owes us, oldest first.
   rsp_type queued_responses[$];

   // Shadow copy of the accelerator's registers.
   logic                msi_on;
   logic [STATUS_W-1:0] status_q;
   logic [FLAGS_W-1:0]  flags_q;
   logic [DATA_W-1:0]   key_q;
   logic [63:0]         src_q;
   logic [63:0]         dst_q;
   logic [DATA_W-1:0]   len_q;
   logic [IRQ_W-1:0]    pending_q;
   logic [DATA_W-1:0]   mask_q;
   logic [DATA_W-1:0]   done_q;
   logic [DATA_W-1:0]   err_q;
   logic [TEMP_W-1:0]   temp_q;
   logic                line_q;
   logic                pulse_q;

   // An interrupt always latches its pending bit. In message mode it fires a pulse for the
   // current word; in level mode it forces the line high regardless of the mask.
   function automatic void raise_interrupt(input logic [IRQ_W-1:0] bits);
      pending_q = pending_q | bits;
      if (msi_on) begin
         pulse_q = 1'b1;
      end else begin
         line_q = 1'b1;
      end
   endfunction

   function automatic void refresh_line();
      if (!msi_on) begin
         line_q = ((pending_q & mask_q[IRQ_W-1:0]) != '0);
      end
   endfunction

   // Soft reset values; the die temperature survives, and so does the line in message mode.
   function automatic void clear_registers();
      status_q  = ST_IDLE;
      flags_q   = '0;
      key_q     = '0;
      src_q     = '0;
      dst_q     = '0;
      len_q     = '0;
      pending_q = '0;
      mask_q    = '0;
      done_q    = '0;
      err_q     = '0;
      if (!msi_on) begin
         line_q = 1'b0;
      end
   endfunction

   // Applies one accepted word to the shadow registers and returns the result it produces.
   function automatic rsp_type accelerator_response(input req_type w);
      rsp_type r;
      int      prev;
      int      noise;
      int      t;
      r = '0;
      pulse_q = 1'b0;
      case (w.cmd)
         CMD_READ: begin
            case (w.reg_offset)
               OFS_ID:       r.read_data = ID_VALUE;
               OFS_STATUS:   r.read_data = DATA_W'(status_q);
               OFS_KEY:      r.read_data = key_q;
               OFS_SRC_LO:   r.read_data = src_q[31:0];
               OFS_SRC_HI:   r.read_data = src_q[63:32];
               OFS_DST_LO:   r.read_data = dst_q[31:0];
               OFS_DST_HI:   r.read_data = dst_q[63:32];
               OFS_LENGTH:   r.read_data = len_q;
               OFS_IRQ_STAT: r.read_data = DATA_W'(pending_q);
               OFS_IRQ_MASK: r.read_data = mask_q;
               OFS_DONE_CNT: r.read_data = done_q;
               OFS_ERR_CNT:  r.read_data = err_q;
               OFS_TEMP:     r.read_data = DATA_W'(temp_q);
               default:      r.read_data = '0;
            endcase
         end
         CMD_WRITE: begin
            case (w.reg_offset)
               OFS_CONTROL: begin
                  // A start is only honored while no job is running.
                  if (w.write_data[0] && (status_q & ST_BUSY) == '0) begin
                     if (len_q > BUFFER_BYTES) begin
                        status_q = ST_IDLE | ST_ERROR;
                        err_q++;
                        if (w.write_data[1]) begin
                           raise_interrupt(IRQ_ERR);
                        end
                     end else begin
                        flags_q = w.write_data[4:1];
                        status_q = ST_BUSY;
                        r.job_started = 1'b1;
                     end
                  end
               end
               OFS_KEY:    key_q = w.write_data;
               OFS_SRC_LO: src_q[31:0] = w.write_data;
               OFS_SRC_HI: src_q[63:32] = w.write_data;
               OFS_DST_LO: dst_q[31:0] = w.write_data;
               OFS_DST_HI: dst_q[63:32] = w.write_data;
               OFS_LENGTH: len_q = w.write_data;
               OFS_IRQ_STAT: begin
                  pending_q = pending_q & ~w.write_data[IRQ_W-1:0];
                  refresh_line();
               end
               OFS_IRQ_MASK: begin
                  mask_q = w.write_data;
                  refresh_line();
               end
               OFS_RESET: begin
                  if (w.write_data == RESET_MAGIC) begin
                     clear_registers();
                  end
               end
               default: ;
            endcase
         end
         CMD_COMPLETE: begin
            // The length is checked again, since it may have been rewritten mid-job.
            if ((status_q & ST_BUSY) != '0) begin
               if (len_q > BUFFER_BYTES) begin
                  status_q = ST_IDLE | ST_ERROR;
                  err_q++;
                  if (flags_q[FLAG_IRQ_EN]) begin
                     raise_interrupt(IRQ_ERR);
                  end
               end else begin
                  status_q = ST_IDLE | ST_DONE;
                  done_q++;
                  if (flags_q[FLAG_IRQ_EN]) begin
                     raise_interrupt(IRQ_DONE);
                  end
               end
            end
         end
         CMD_TICK: begin
            prev = temp_q;
            noise = w.temp_noise[NOISE_W-2:0];
            if (w.temp_noise[NOISE_W-1]) begin
               noise -= 16;
            end
            t = prev + noise + (int'(TEMP_MEAN) - prev) / TEMP_PULL_DIV;
            if (t < int'(TEMP_LOW)) begin
               t = TEMP_LOW;
            end
            if (t > int'(TEMP_HIGH)) begin
               t = TEMP_HIGH;
            end
            temp_q = t[TEMP_W-1:0];
            if (t > int'(TEMP_LIMIT) && prev <= int'(TEMP_LIMIT)) begin
               raise_interrupt(IRQ_TEMP);
            end
         end
         CMD_FAULT: begin
            if ((status_q & ST_IDLE) != '0 && w.fault_roll < FAULT_PERCENT) begin
               status_q = ST_IDLE | ST_ERROR;
               err_q++;
               raise_interrupt(IRQ_ERR);
            end
         end
         CMD_BYTE: begin
            r.xored_byte = w.byte_value;
            if (flags_q[FLAG_ENCRYPT]) begin
               r.xored_byte = r.xored_byte ^ key_q[8*w.byte_index[1:0] +: 8];
            end
         end
         default: ;
      endcase
      r.irq_level = line_q;
      r.msi_pulse = pulse_q;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      failures++;
      if (failures <= 100) begin
         $display("MISMATCH %s: got 0x%08h, wanted 0x%08h at %0t", what, got, want, $time);
      end
   endtask

   // All fields random, so bits that the command does not use still toggle.
   function automatic req_type random_word();
      req_type w;
      w.cmd        = CMD_W'($urandom_range(7));
      w.reg_offset = OFFS_W'($urandom_range(4095));
      w.write_data = $urandom;
      w.temp_noise = NOISE_W'($urandom_range(31));
      w.fault_roll = ROLL_W'($urandom_range(127));
      w.byte_index = INDEX_W'($urandom_range(65535));
      w.byte_value = BYTE_W'($urandom_range(255));
      return w;
   endfunction

   function automatic logic [OFFS_W-1:0] any_register();
      return OFS_ID + OFFS_W'(4 * $urandom_range(14));
   endfunction

   function automatic logic [DATA_W-1:0] job_length();
      case ($urandom_range(9))
         0:       return BUFFER_BYTES;
         1:       return BUFFER_BYTES + 1;
         2:       return $urandom;
         default: return $urandom_range(4096);
      endcase
   endfunction

   // Presents one word, holding it until the block takes it; the model advances at that edge.
   // Valid stays high afterwards, so back-to-back words go out without valid dropping between them.
   task automatic send_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= w.cmd;
      req_bus.reg_offset <= w.reg_offset;
      req_bus.write_data <= w.write_data;
      req_bus.temp_noise <= w.temp_noise;
      req_bus.fault_roll <= w.fault_roll;
      req_bus.byte_index <= w.byte_index;
      req_bus.byte_value <= w.byte_value;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      queued_responses.push_back(accelerator_response(w));
      words_sent++;
   endtask

   task automatic send_read(input logic [OFFS_W-1:0] ofs);
      req_type w;
      w = random_word();
      w.cmd = CMD_READ;
      w.reg_offset = ofs;
      send_word(w);
   endtask

   task automatic send_write(input logic [OFFS_W-1:0] ofs, input logic [DATA_W-1:0] data);
      req_type w;
      w = random_word();
      w.cmd = CMD_WRITE;
      w.reg_offset = ofs;
      w.write_data = data;
      send_word(w);
   endtask

   task automatic send_complete();
      req_type w;
      w = random_word();
      w.cmd = CMD_COMPLETE;
      send_word(w);
   endtask

   task automatic send_tick(input int noise);
      req_type w;
      w = random_word();
      w.cmd = CMD_TICK;
      w.temp_noise = noise[NOISE_W-1:0];
      send_word(w);
   endtask

   task automatic send_fault(input int roll);
      req_type w;
      w = random_word();
      w.cmd = CMD_FAULT;
      w.fault_roll = roll[ROLL_W-1:0];
      send_word(w);
   endtask

   task automatic send_byte(input int index, input int value);
      req_type w;
      w = random_word();
      w.cmd = CMD_BYTE;
      w.byte_index = index[INDEX_W-1:0];
      w.byte_value = value[BYTE_W-1:0];
      send_word(w);
   endtask

   // Drops valid and waits until every owed result is back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (queued_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // APB write of the mode register, done only with the pipeline empty.
   task automatic write_msi_mode(input logic mode);
      drain_responses();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 2'(CSR_MSI_MODE * 4);
      pwdata  <= DATA_W'(mode);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      msi_on = mode;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Register map: ID, split addresses, a write to a read-only offset, a misaligned read, an
   // unknown-offset read, and a control write without the start bit.
   task automatic test_register_access();
      send_read(OFS_ID);
      send_write(OFS_SRC_LO, 32'hFFFF_FFFF);
      send_write(OFS_DST_HI, 32'hFFFF_FFFF);
      send_write(OFS_KEY, 32'hA5C3_1E7F);
      send_write(OFS_ID, 32'h0);
      send_read(OFS_SRC_LO);
      send_read(OFS_DST_HI);
      send_read(OFS_ID + OFFS_W'(2));
      send_read(12'hFFC);
      send_write(OFS_CONTROL, 32'hFFFF_FFFE);
   endtask

   // Job life cycle: a good start with encryption, a start while busy, a fault while busy,
   // completion with and without a job, write-one-to-clear, and both length errors.
   task automatic test_job_control();
      send_write(OFS_LENGTH, BUFFER_BYTES);
      send_write(OFS_IRQ_MASK, 32'h1);
      send_write(OFS_CONTROL, 32'h1F);
      send_write(OFS_CONTROL, 32'h1F);
      send_fault(0);
      send_byte(0, 0);
      send_byte(65535, 255);
      send_complete();
      send_complete();
      send_write(OFS_IRQ_STAT, 32'hFFFF_FFFF);
      send_write(OFS_LENGTH, BUFFER_BYTES + 1);
      send_write(OFS_CONTROL, 32'h3);
      send_write(OFS_LENGTH, 32'h8);
      send_write(OFS_CONTROL, 32'h1);
      send_write(OFS_LENGTH, 32'hFFFF_FFFF);
      send_complete();
   endtask

   // Fault rolls on both sides of the threshold, a heat run across the interrupt limit, the
   // cold extreme of the noise, both soft reset values, and the unused commands.
   task automatic test_sensor_events();
      req_type w;
      send_fault(FAULT_PERCENT - 1);
      send_fault(127);
      repeat (4) send_tick(15);
      repeat (3) send_tick(-16);
      send_read(OFS_TEMP);
      send_write(OFS_RESET, 32'h0);
      send_write(OFS_RESET, RESET_MAGIC);
      w = random_word();
      w.cmd = CMD_SPARE_LO;
      send_word(w);
      w.cmd = CMD_SPARE_HI;
      send_word(w);
   endtask

   // Message mode: interrupts become pulses and neither the mask nor a soft reset moves the line.
   task automatic test_message_interrupts();
      write_msi_mode(1'b1);
      send_fault(0);
      send_write(OFS_IRQ_MASK, 32'h7);
      send_write(OFS_RESET, RESET_MAGIC);
      send_write(OFS_CONTROL, 32'h3);
      send_complete();
   endtask

   // Mostly complete jobs with random content, mixed with heat and cold runs, faults, soft
   // resets and fully random words.
   task automatic run_traffic(input int word_count);
      int                stop_at;
      int                n;
      int                bias;
      logic [DATA_W-1:0] ctrl;
      stop_at = words_sent + word_count;
      while (words_sent < stop_at) begin
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
               if ($urandom_range(3) != 0) begin
                  send_write(OFS_LENGTH, job_length());
               end
               if ($urandom_range(1)) begin
                  send_write(OFS_KEY, $urandom);
               end
               if ($urandom_range(3) == 0) begin
                  send_write(OFS_IRQ_MASK, $urandom_range(1) ? 32'h7 : $urandom);
               end
               ctrl = $urandom;
               if ($urandom_range(9) != 0) begin
                  ctrl[0] = 1'b1;
               end
               send_write(OFS_CONTROL, ctrl);
               n = $urandom_range(6);
               repeat (n) send_byte($urandom_range(65535), $urandom_range(255));
               if ($urandom_range(3) == 0) begin
                  send_read(OFS_STATUS);
               end
               if ($urandom_range(9) == 0) begin
                  send_fault($urandom_range(127));
               end
               if ($urandom_range(9) == 0) begin
                  send_write(OFS_LENGTH, job_length());
               end
               send_complete();
               if ($urandom_range(1)) begin
                  send_read(any_register());
               end
               if ($urandom_range(2) == 0) begin
                  send_write(OFS_IRQ_STAT, $urandom_range(7));
               end
            end
            10, 11, 12: begin
               n = $urandom_range(1, 8);
               bias = $urandom_range(2);
               repeat (n) begin
                  case (bias)
                     0:       send_tick($urandom_range(8, 15));
                     1:       send_tick(int'($urandom_range(8)) - 16);
                     default: send_tick(int'($urandom_range(31)) - 16);
                  endcase
               end
               if ($urandom_range(1)) begin
                  send_read(OFS_TEMP);
               end
            end
            13, 14: begin
               n = $urandom_range(1, 3);
               repeat (n) send_fault($urandom_range(1) ? $urandom_range(14) : $urandom_range(127));
               send_read(OFS_ERR_CNT);
            end
            15: begin
               send_write(OFS_RESET, $urandom_range(1) ? RESET_MAGIC : $urandom);
            end
            default: begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  req_type w;
                  w = random_word();
                  if ($urandom_range(1)) begin
                     w.reg_offset = any_register();
                  end
                  send_word(w);
               end
            end
         endcase
      end
   endtask

   // Four idling profiles, each run once in level mode and once in message mode.
   task automatic test_random_traffic();
      int idle_plan[4]  = '{0, 79, 0, 15};
      int stall_plan[4] = '{0, 0, 79, 15};
      for (int p = 0; p < 8; p++) begin
         write_msi_mode(p[0]);
         send_idle_pct = idle_plan[p / 2];
         stall_pct = stall_plan[p / 2];
         run_traffic(220);
      end
   endtask

   // Result side: compare every accepted word with the oldest owed result, then pick the ready
   // level for the next cycle from the current stall odds.
   initial begin
      rsp_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (queued_responses.size() == 0) begin
               report_mismatch("word with nothing owed", rsp_bus.read_data, '0);
            end else begin
               want = queued_responses.pop_front();
               if (rsp_bus.read_data !== want.read_data) begin
                  report_mismatch("read_data", rsp_bus.read_data, want.read_data);
               end
               if (rsp_bus.irq_level !== want.irq_level) begin
                  report_mismatch("irq_level", DATA_W'(rsp_bus.irq_level),
                                  DATA_W'(want.irq_level));
               end
               if (rsp_bus.msi_pulse !== want.msi_pulse) begin
                  report_mismatch("msi_pulse", DATA_W'(rsp_bus.msi_pulse),
                                  DATA_W'(want.msi_pulse));
               end
               if (rsp_bus.xored_byte !== want.xored_byte) begin
                  report_mismatch("xored_byte", DATA_W'(rsp_bus.xored_byte),
                                  DATA_W'(want.xored_byte));
               end
               if (rsp_bus.job_started !== want.job_started) begin
                  report_mismatch("job_started", DATA_W'(rsp_bus.job_started),
                                  DATA_W'(want.job_started));
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Hang detection: any handshake or configuration access restarts the count.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = '0;
      req_bus.reg_offset = '0;
      req_bus.write_data = '0;
      req_bus.temp_noise = '0;
      req_bus.fault_roll = '0;
      req_bus.byte_index = '0;
      req_bus.byte_value = '0;
      msi_on  = 1'b0;
      line_q  = 1'b0;
      pulse_q = 1'b0;
      clear_registers();
      temp_q = TEMP_MEAN;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_register_access();
      test_job_control();
      test_sensor_events();
      test_message_interrupts();
      test_random_traffic();
      drain_responses();

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/xab_pkg.sv
sv/xab_req_if.sv
sv/xab_rsp_if.sv
sv/xab_temp.sv
sv/xab_core.sv
sv/xor_accelerator_register_block_top.sv
test/tb.sv
